[src/stoe_pkg.sv]
// Shared types and constants of the session table with oldest-entry replacement.
package stoe_pkg;

  // Table geometry and field widths.
  localparam int unsigned TableDepth  = 64;
  localparam int unsigned SlotW       = $clog2(TableDepth);
  localparam int unsigned CountW      = SlotW + 1;
  localparam int unsigned IdW         = 64;
  localparam int unsigned PayloadBits = 64;
  localparam int unsigned TimeBits    = 48;
  localparam int unsigned ReqW        = 2;
  localparam int unsigned ActionW     = 3;

  // Request codes; the fourth code is unused and ignored.
  typedef enum logic [ReqW-1:0] {
    ReqUpsert = 2'd0,
    ReqClear  = 2'd1,
    ReqRead   = 2'd2
  } req_e;

  // Result action codes.
  typedef enum logic [ActionW-1:0] {
    ActUpdated  = 3'd0,
    ActInserted = 3'd1,
    ActReplaced = 3'd2,
    ActIgnored  = 3'd3,
    ActCleared  = 3'd4,
    ActRead     = 3'd5
  } action_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StRead,
    StRdata,
    StResp
  } state_e;

  // One request item.
  typedef struct packed {
    logic [ReqW-1:0]        req_type;
    logic [IdW-1:0]         flow_key;
    logic [PayloadBits-1:0] stats_payload;
    logic [TimeBits-1:0]    timestamp;
    logic [SlotW-1:0]       read_slot;
  } req_t;

  // One result item.
  typedef struct packed {
    action_e                action;
    logic [SlotW-1:0]       slot;
    logic [IdW-1:0]         evicted_id;
    logic                   read_valid;
    logic [IdW-1:0]         read_id;
    logic [PayloadBits-1:0] read_payload;
    logic [TimeBits-1:0]    read_time;
    logic [CountW-1:0]      occupancy;
  } rsp_t;

  // One stored table entry.
  typedef struct packed {
    logic [IdW-1:0]         sid;
    logic [PayloadBits-1:0] payload;
    logic [TimeBits-1:0]    tstamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

[src/stoe_req_if.sv]
// Request channel interface: valid, ready and one request item.
interface stoe_req_if;
  import stoe_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/stoe_rsp_if.sv]
// Result channel interface: valid, ready and one result item.
interface stoe_rsp_if;
  import stoe_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/stoe_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module stoe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/session_table_oldest_eviction.sv]
// Session table: one RAM of entries, a scanning sequencer and a result register.
// Upsert: accept, read the occupied slots in turn (none on an empty table), write back and
// respond; a hit in a low slot ends the scan sooner. The scan is bound by the single RAM
// read port. Read: accept, read the slot, capture and respond; clear and ignored requests
// are accepted and answered. The next item is taken as its result is offered; a stalled
// result holds the following item in its last step. Reset empties the table, limit 64.
module session_table_oldest_eviction (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [stoe_pkg::CountW-1:0] cfg_wdata_i,
  stoe_req_if.sink                    req_i,
  stoe_rsp_if.source                  rsp_o
);
  import stoe_pkg::*;

  state_e              state_q, state_d;
  logic [CountW-1:0]   limit_q;
  logic [CountW-1:0]   count_q;
  req_t                cur_q;
  logic [CountW-1:0]   idx_q;
  logic                rd_vld_q;
  logic [SlotW-1:0]    rd_idx_q;
  logic                hit_q;
  logic [SlotW-1:0]    hit_idx_q;
  logic [SlotW-1:0]    old_idx_q;
  logic [TimeBits-1:0] old_time_q;
  logic [IdW-1:0]      old_id_q;
  rsp_t                res_q, res_d;
  logic                res_load;
  logic                out_vld_q;
  rsp_t                out_q, out_d;

  logic                req_acc;
  logic                out_free;
  logic                scan_issue;
  logic                scan_done;
  logic [CountW-1:0]   eff_limit;
  logic                can_insert;
  logic                ram_re;
  logic [SlotW-1:0]    ram_raddr;
  logic                ram_we;
  logic [SlotW-1:0]    ram_waddr;
  entry_t              ram_wentry;
  logic [EntryW-1:0]   ram_rdata;
  entry_t              rd_entry;
  logic                rd_in_range;

  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign rd_entry    = entry_t'(ram_rdata);
  assign rd_in_range = {1'b0, cur_q.read_slot} < count_q;

  // Effective limit: zero acts as one, anything above the depth acts as the depth.
  always_comb begin
    if (limit_q == '0) begin
      eff_limit = CountW'(1);
    end else if (limit_q > CountW'(TableDepth)) begin
      eff_limit = CountW'(TableDepth);
    end else begin
      eff_limit = limit_q;
    end
  end
  assign can_insert = count_q < eff_limit;

  // The scan issues one read a cycle until every occupied slot is read or a hit is seen.
  assign scan_issue = (state_q == StScan) && !hit_q && (idx_q != count_q);
  assign scan_done  = !rd_vld_q && (hit_q || (idx_q == count_q));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_acc) begin
          case (req_i.data.req_type)
            ReqUpsert: state_d = (req_i.data.flow_key != '0) ? StScan : StResp;
            ReqRead:   state_d = StRead;
            default:   state_d = StResp;
          endcase
        end
      end
      StScan:   if (scan_done) state_d = StDecide;
      StDecide: state_d = StResp;
      StRead:   state_d = StRdata;
      StRdata:  state_d = StResp;
      StResp:   if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer: RAM controls and the result under construction.
  always_comb begin
    req_i.ready = (state_q == StIdle);
    ram_re      = 1'b0;
    ram_raddr   = idx_q[SlotW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = old_idx_q;
    ram_wentry  = '{sid: cur_q.flow_key, payload: cur_q.stats_payload,
                    tstamp: cur_q.timestamp};
    res_load    = 1'b0;
    res_d       = '0;
    res_d.action = ActIgnored;
    case (state_q)
      StIdle: begin
        res_load = req_acc;
        if (req_i.data.req_type == ReqClear) begin
          res_d.action = ActCleared;
        end
      end
      StScan: begin
        ram_re = scan_issue;
      end
      StDecide: begin
        ram_we   = 1'b1;
        res_load = 1'b1;
        if (hit_q) begin
          ram_waddr    = hit_idx_q;
          res_d.action = ActUpdated;
          res_d.slot   = hit_idx_q;
        end else if (can_insert) begin
          ram_waddr    = count_q[SlotW-1:0];
          res_d.action = ActInserted;
          res_d.slot   = count_q[SlotW-1:0];
        end else begin
          ram_waddr        = old_idx_q;
          res_d.action     = ActReplaced;
          res_d.slot       = old_idx_q;
          res_d.evicted_id = old_id_q;
        end
      end
      StRead: begin
        ram_re    = 1'b1;
        ram_raddr = cur_q.read_slot;
      end
      StRdata: begin
        res_load     = 1'b1;
        res_d.action = ActRead;
        res_d.slot   = cur_q.read_slot;
        if (rd_in_range) begin
          res_d.read_valid   = 1'b1;
          res_d.read_id      = rd_entry.sid;
          res_d.read_payload = rd_entry.payload;
          res_d.read_time    = rd_entry.tstamp;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry storage.
  stoe_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // State, limit and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      limit_q <= CountW'(TableDepth);
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (req_acc && (req_i.data.req_type == ReqClear)) begin
        count_q <= '0;
      end else if ((state_q == StDecide) && !hit_q && can_insert) begin
        count_q <= count_q + CountW'(1);
      end
    end
  end

  // Scan control: read index, read-in-flight flag and hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (req_acc) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      rd_vld_q <= scan_issue;
      if (scan_issue) begin
        idx_q <= idx_q + CountW'(1);
      end
      if ((state_q == StScan) && rd_vld_q && (rd_entry.sid == cur_q.flow_key)) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Captured item and the running match and oldest-entry search.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cur_q <= req_i.data;
    end
    if (scan_issue) begin
      rd_idx_q <= idx_q[SlotW-1:0];
    end
    if ((state_q == StScan) && rd_vld_q) begin
      if (!hit_q && (rd_entry.sid == cur_q.flow_key)) begin
        hit_idx_q <= rd_idx_q;
      end
      if ((rd_idx_q == '0) || (rd_entry.tstamp < old_time_q)) begin
        old_idx_q  <= rd_idx_q;
        old_time_q <= rd_entry.tstamp;
        old_id_q   <= rd_entry.sid;
      end
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // The result leaves with the occupancy as this request has left it.
  always_comb begin
    out_d           = res_q;
    out_d.occupancy = count_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == StResp) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StResp) && out_free) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  // A clear empties the table by the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_i.data.req_type == ReqClear)) |=> (count_q == '0))
    else $error("occupancy not zero after a clear");

  // Only a clear lowers the occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_acc && (req_i.data.req_type == ReqClear)) |=> (count_q >= $past(count_q)))
    else $error("occupancy fell without a clear");

  // The scan never reads a slot at or above the occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && (state_q == StScan)) |-> (idx_q < count_q))
    else $error("scan read beyond the occupied slots");

  // The occupancy never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDecide) && !hit_q && can_insert) |-> (count_q < CountW'(TableDepth)))
    else $error("insert into a full table");

endmodule

[test/tb_session_table_oldest_eviction.sv]
// Self-checking testbench for the session table with oldest-entry replacement.
module tb_session_table_oldest_eviction;
  timeunit 1ns;
  timeprecision 1ps;

  import stoe_pkg::*;

  // The fourth request code has no meaning and must be ignored.
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;
  localparam int unsigned PhaseItems = 180;
  localparam int unsigned PrintCap = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  stoe_req_if req_if ();
  stoe_rsp_if rsp_if ();

  session_table_oldest_eviction uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the table and its limit, advanced as each item is accepted.
  logic [IdW-1:0]         shadow_id      [TableDepth];
  logic [PayloadBits-1:0] shadow_payload [TableDepth];
  logic [TimeBits-1:0]    shadow_time    [TableDepth];
  int unsigned            shadow_count;
  logic [CountW-1:0]      cap_setting;

  req_t request_q [$];
  rsp_t outcome_q [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned send_hold;
  int unsigned sink_hold;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  // Work out the result of one request and update the shadow table.
  function automatic rsp_t predict_session_op(req_t r);
    rsp_t o;
    int unsigned cap;
    int unsigned hit_at;
    int unsigned oldest_at;
    bit hit;
    o = '0;
    o.action = ActIgnored;
    cap = (cap_setting == 0) ? 1 : ((cap_setting > TableDepth) ? TableDepth : cap_setting);
    case (r.req_type)
      ReqUpsert: begin
        if (r.flow_key != '0) begin
          hit = 1'b0;
          hit_at = 0;
          oldest_at = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if (!hit && shadow_id[i] == r.flow_key) begin
              hit = 1'b1;
              hit_at = i;
            end
            if (shadow_time[i] < shadow_time[oldest_at]) oldest_at = i;
          end
          if (hit) begin
            o.action = ActUpdated;
            o.slot = SlotW'(hit_at);
          end else if (shadow_count < cap) begin
            hit_at = shadow_count;
            shadow_count++;
            o.action = ActInserted;
            o.slot = SlotW'(hit_at);
          end else begin
            hit_at = oldest_at;
            o.evicted_id = shadow_id[oldest_at];
            o.action = ActReplaced;
            o.slot = SlotW'(hit_at);
          end
          shadow_id[hit_at] = r.flow_key;
          shadow_payload[hit_at] = r.stats_payload;
          shadow_time[hit_at] = r.timestamp;
        end
      end
      ReqClear: begin
        shadow_count = 0;
        o.action = ActCleared;
      end
      ReqRead: begin
        o.action = ActRead;
        o.slot = r.read_slot;
        if (r.read_slot < shadow_count) begin
          o.read_valid = 1'b1;
          o.read_id = shadow_id[r.read_slot];
          o.read_payload = shadow_payload[r.read_slot];
          o.read_time = shadow_time[r.read_slot];
        end
      end
      default: ;
    endcase
    o.occupancy = CountW'(shadow_count);
    return o;
  endfunction

  // Print one failure line while under the print cap, and count it.
  task automatic report_fault(string msg);
    if (mismatch_count < PrintCap) $display("result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  // Compare one received result against the oldest outstanding prediction.
  task automatic check_outcome(rsp_t got);
    rsp_t want;
    if (outcome_q.size() == 0) begin
      report_fault("result arrived with no request outstanding");
    end else begin
      want = outcome_q.pop_front();
      if (got.action !== want.action)
        report_fault($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.slot !== want.slot)
        report_fault($sformatf("slot got %0d want %0d", got.slot, want.slot));
      if (got.evicted_id !== want.evicted_id)
        report_fault($sformatf("evicted_id got %h want %h", got.evicted_id, want.evicted_id));
      if (got.read_valid !== want.read_valid)
        report_fault($sformatf("read_valid got %b want %b", got.read_valid, want.read_valid));
      if (got.read_id !== want.read_id)
        report_fault($sformatf("read_id got %h want %h", got.read_id, want.read_id));
      if (got.read_payload !== want.read_payload)
        report_fault($sformatf("read_payload got %h want %h", got.read_payload,
                               want.read_payload));
      if (got.read_time !== want.read_time)
        report_fault($sformatf("read_time got %h want %h", got.read_time, want.read_time));
      if (got.occupancy !== want.occupancy)
        report_fault($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
    end
    results_seen++;
  endtask

  function automatic int unsigned draw_pause(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic req_t build_req(logic [ReqW-1:0] kind, logic [IdW-1:0] sid,
                                     logic [PayloadBits-1:0] pay, logic [TimeBits-1:0] ts,
                                     logic [SlotW-1:0] rs);
    req_t r;
    r.req_type = kind;
    r.flow_key = sid;
    r.stats_payload = pay;
    r.timestamp = ts;
    r.read_slot = rs;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Request driver: presents queued items, with a drawn pause after each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      send_hold <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        outcome_q.push_back(predict_session_op(req_if.data));
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_hold != 0) begin
          req_if.valid <= 1'b0;
          send_hold <= send_hold - 1;
        end else if (request_q.size() != 0) begin
          req_if.data <= request_q.pop_front();
          req_if.valid <= 1'b1;
          send_hold <= draw_pause(src_quiet);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted item, then stalls for a drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    int unsigned next_wait;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      sink_hold <= 0;
    end else begin
      next_wait = sink_hold;
      if (rsp_if.valid && rsp_if.ready) begin
        check_outcome(rsp_if.data);
        next_wait = draw_pause(sink_quiet);
      end
      if (next_wait != 0) begin
        rsp_if.ready <= 1'b0;
        sink_hold <= next_wait - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        sink_hold <= 0;
      end
    end
  end

  // Wait until every queued item has been taken and every result has come back.
  task automatic settle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || req_if.valid || outcome_q.size() != 0);
  endtask

  // Write the session limit while the table is idle.
  task automatic write_limit(logic [CountW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_setting = value;
  endtask

  // Stimulus: directed corner cases, then random phases over several limits.
  initial begin : stimulus
    int limit_plan [10] = '{64, 3, 0, 1, 127, 17, 64, 100, 5, 63};
    logic [IdW-1:0] id_pool [$];
    logic [TimeBits-1:0] tick;
    logic [TimeBits-1:0] ts;
    logic [IdW-1:0] sid;
    int unsigned cap;
    int unsigned roll;
    logic [TimeBits-1:0] t_max;

    t_max = '1;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    shadow_count = 0;
    cap_setting = CountW'(64);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with a limit of two, so that replacement comes quickly.
    write_limit(CountW'(2));
    request_q.push_back(build_req(ReqRead, rand64(), rand64(), '0, 6'd0));
    request_q.push_back(build_req(ReqUpsert, 64'd1, '0, 48'd5, '0));
    request_q.push_back(build_req(ReqUpsert, '1, '1, 48'd5, '1));
    request_q.push_back(build_req(ReqUpsert, 64'd1, 64'h5555_5555_5555_5555, t_max, '0));
    request_q.push_back(build_req(ReqUpsert, '0, '1, t_max, '1));
    request_q.push_back(build_req(ReqUnused, '1, '1, t_max, '1));
    // Slot one holds the older time, so it is replaced.
    request_q.push_back(build_req(ReqUpsert, 64'd3, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0));
    request_q.push_back(build_req(ReqRead, '0, '0, '0, 6'd0));
    request_q.push_back(build_req(ReqRead, '0, '0, '0, 6'd1));
    request_q.push_back(build_req(ReqRead, '0, '0, '0, 6'd63));
    // Both slots at time zero: the lower slot must be the one replaced.
    request_q.push_back(build_req(ReqUpsert, 64'd1, 64'd7, '0, '0));
    request_q.push_back(build_req(ReqUpsert, 64'd5, 64'd9, 48'd9, '0));
    request_q.push_back(build_req(ReqRead, '0, '0, '0, 6'd0));
    request_q.push_back(build_req(ReqClear, '1, '1, t_max, '1));
    request_q.push_back(build_req(ReqRead, '0, '0, '0, 6'd0));
    request_q.push_back(build_req(ReqUpsert, 64'h8000_0000_0000_0000, '1, 48'd1, '0));
    request_q.push_back(build_req(ReqRead, '1, '1, t_max, 6'd0));
    request_q.push_back(build_req(ReqUpsert, 64'h8000_0000_0000_0000, '0, 48'd2, '0));
    settle();

    // Random phases; a lowered limit keeps the entries already held.
    tick = 48'd100;
    foreach (limit_plan[p]) begin
      write_limit(CountW'(limit_plan[p]));
      cap = (limit_plan[p] == 0) ? 1 : ((limit_plan[p] > TableDepth) ? TableDepth
                                                                     : limit_plan[p]);
      src_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      id_pool.delete();
      repeat (cap + $urandom_range(1, 10)) begin
        sid = rand64();
        id_pool.push_back((sid == '0) ? 64'd1 : sid);
      end
      repeat (PhaseItems) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          sid = ($urandom_range(0, 9) != 0) ? id_pool[$urandom_range(0, id_pool.size() - 1)]
                                            : rand64();
          if (sid == '0) sid = 64'd2;
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            tick = tick + TimeBits'($urandom_range(0, 3));
            ts = tick;
          end else if (roll < 80) begin
            ts = tick - TimeBits'($urandom_range(0, 50));
          end else if (roll < 90) begin
            ts = TimeBits'({$urandom, $urandom});
          end else if (roll < 95) begin
            ts = '0;
          end else begin
            ts = t_max;
          end
          request_q.push_back(build_req(ReqUpsert, sid, rand64(), ts, SlotW'($urandom)));
        end else if (roll < 83) begin
          request_q.push_back(build_req(ReqUpsert, '0, rand64(),
                                        TimeBits'({$urandom, $urandom}), SlotW'($urandom)));
        end else if (roll < 94) begin
          request_q.push_back(build_req(ReqRead, rand64(), rand64(),
                                        TimeBits'({$urandom, $urandom}),
                                        SlotW'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                                    : $urandom_range(0, cap - 1))));
        end else if (roll < 96) begin
          request_q.push_back(build_req(ReqClear, rand64(), rand64(),
                                        TimeBits'({$urandom, $urandom}), SlotW'($urandom)));
        end else begin
          request_q.push_back(build_req(ReqUnused, rand64(), rand64(),
                                        TimeBits'({$urandom, $urandom}), SlotW'($urandom)));
        end
      end
      settle();
    end

    // Drain: catch any stray result after the last expected one.
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
